[hdl/loci_pkg.sv]
// Shared constants, types and helper functions for the linear octree cell index block.
`timescale 1ns / 1ps

package loci_pkg;

  // Depth of the octree; the grid has 2^LEVELS positions per axis.
  localparam int LEVELS = 5;
  localparam int POS_W  = LEVELS;
  localparam int CODE_W = 3 * LEVELS;
  localparam int UP_W   = $clog2(LEVELS + 1);
  localparam int COORD_W = 32;
  localparam int INDEX_W = 16;
  localparam int LEVEL_W = 3;

  // Configuration register indexes.
  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;
  localparam logic [2:0] REG_INV_SIZE  = 3'd6;

  localparam logic [31:0] INV_SIZE_RESET = 32'h0001_0000;

  // Operation codes carried in tuser.
  localparam logic OP_POINT    = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  // Per-axis result of the bounds stage.
  typedef struct packed {
    logic [COORD_W-1:0] off_lo;
    logic [COORD_W-1:0] off_hi;
    logic               out;
  } axis_span_t;

  // Number of cells on all levels above the given one, (8^lvl - 1) / 7, modulo 2^16.
  function automatic logic [INDEX_W-1:0] level_offset(input logic [UP_W-1:0] lvl);
    logic [INDEX_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (UP_W'(i) < lvl) begin
        acc = acc + INDEX_W'(64'd1 << (3 * i));
      end
    end
    return acc;
  endfunction

  // Interleave three grid positions into a Morton code, z above y above x.
  function automatic logic [CODE_W-1:0] morton(input logic [POS_W-1:0] x,
                                               input logic [POS_W-1:0] y,
                                               input logic [POS_W-1:0] z);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = 0; b < LEVELS; b++) begin
      code[3*b]     = x[b];
      code[3*b + 1] = y[b];
      code[3*b + 2] = z[b];
    end
    return code;
  endfunction

endpackage

[hdl/loci_bound.sv]
// Bounding interval, bounds check and offset from the cube minimum for one axis.
`timescale 1ns / 1ps

module loci_bound (
  input  logic                               op,
  input  logic signed [loci_pkg::COORD_W-1:0] c0,
  input  logic signed [loci_pkg::COORD_W-1:0] c1,
  input  logic signed [loci_pkg::COORD_W-1:0] c2,
  input  logic signed [loci_pkg::COORD_W-1:0] lo,
  input  logic signed [loci_pkg::COORD_W-1:0] hi,
  output loci_pkg::axis_span_t                span
);

  logic signed [loci_pkg::COORD_W-1:0] vmin;
  logic signed [loci_pkg::COORD_W-1:0] vmax;
  logic signed [loci_pkg::COORD_W-1:0] m01;
  logic signed [loci_pkg::COORD_W-1:0] x01;
  logic        [loci_pkg::COORD_W:0]   d_lo;
  logic        [loci_pkg::COORD_W:0]   d_hi;

  always_comb begin
    m01 = (c1 < c0) ? c1 : c0;
    x01 = (c1 > c0) ? c1 : c0;
    // A point uses its only vertex for both corners.
    if (op == loci_pkg::OP_TRIANGLE) begin
      vmin = (c2 < m01) ? c2 : m01;
      vmax = (c2 > x01) ? c2 : x01;
    end else begin
      vmin = c0;
      vmax = c0;
    end
    d_lo = {vmin[loci_pkg::COORD_W-1], vmin} - {lo[loci_pkg::COORD_W-1], lo};
    d_hi = {vmax[loci_pkg::COORD_W-1], vmax} - {lo[loci_pkg::COORD_W-1], lo};
    // A coordinate below the cube maps to grid position zero.
    span.off_lo = d_lo[loci_pkg::COORD_W] ? '0 : d_lo[loci_pkg::COORD_W-1:0];
    span.off_hi = d_hi[loci_pkg::COORD_W] ? '0 : d_hi[loci_pkg::COORD_W-1:0];
    span.out    = (c0 < lo) || (c0 > hi);
  end

endmodule

[hdl/loci_scale.sv]
// Scaling of one offset into grid units, with saturation to the grid edge.
`timescale 1ns / 1ps

module loci_scale (
  input  logic [loci_pkg::COORD_W-1:0] off,
  input  logic [31:0]                  inv_size,
  output logic [loci_pkg::POS_W-1:0]   grid_pos
);

  logic [63:0] prod;

  always_comb begin
    prod = 64'(off) * 64'(inv_size);
    // The integer part of the Q32.32 product is the grid position.
    if (prod[63:32+loci_pkg::POS_W] != '0) begin
      grid_pos = '1;
    end else begin
      grid_pos = prod[32 +: loci_pkg::POS_W];
    end
  end

endmodule

[hdl/loci_encode.sv]
// Morton coding, shared level search and final cell index.
`timescale 1ns / 1ps

module loci_encode (
  input  logic                              op,
  input  logic                              outside,
  input  logic [loci_pkg::POS_W-1:0]        lo_x,
  input  logic [loci_pkg::POS_W-1:0]        lo_y,
  input  logic [loci_pkg::POS_W-1:0]        lo_z,
  input  logic [loci_pkg::POS_W-1:0]        hi_x,
  input  logic [loci_pkg::POS_W-1:0]        hi_y,
  input  logic [loci_pkg::POS_W-1:0]        hi_z,
  output logic [loci_pkg::INDEX_W-1:0]      cell_index,
  output logic [loci_pkg::LEVEL_W-1:0]      space_level
);

  logic [loci_pkg::CODE_W-1:0] code_lo;
  logic [loci_pkg::CODE_W-1:0] code_hi;
  logic [loci_pkg::CODE_W-1:0] diff;
  logic [loci_pkg::CODE_W-1:0] shifted;
  logic [loci_pkg::UP_W-1:0]   up;
  logic [loci_pkg::UP_W-1:0]   lvl;
  logic [loci_pkg::UP_W+1:0]   shamt;

  always_comb begin
    code_lo = loci_pkg::morton(lo_x, lo_y, lo_z);
    code_hi = loci_pkg::morton(hi_x, hi_y, hi_z);
    diff    = code_lo ^ code_hi;
    // The highest differing octal digit sets how many levels the triangle climbs.
    up = '0;
    for (int k = 0; k < loci_pkg::LEVELS; k++) begin
      if (diff[3*k +: 3] != 3'd0) begin
        up = loci_pkg::UP_W'(k + 1);
      end
    end
    shamt   = (loci_pkg::UP_W+2)'(up) + ((loci_pkg::UP_W+2)'(up) << 1);
    shifted = code_hi >> shamt;

    if (op == loci_pkg::OP_TRIANGLE) begin
      lvl        = loci_pkg::UP_W'(loci_pkg::LEVELS) - up;
      cell_index = loci_pkg::INDEX_W'(shifted) + loci_pkg::level_offset(lvl);
    end else if (outside) begin
      lvl        = '0;
      cell_index = '0;
    end else begin
      lvl        = loci_pkg::UP_W'(loci_pkg::LEVELS);
      cell_index = loci_pkg::INDEX_W'(code_lo) + loci_pkg::level_offset(lvl);
    end
    space_level = loci_pkg::LEVEL_W'(lvl);
  end

endmodule

[hdl/linear_octree_cell_index.sv]
// Top level of the linear octree cell index block: ports, configuration and pipeline.
`timescale 1ns / 1ps

// Maps one point or one triangle per request to its cell in a linear octree over the
// configured cube. The block takes a request in every cycle while s_axis_tready is high
// and passes it through an input register, a bounds stage, a stage of 32 by 32 bit
// multipliers that scale offsets into grid units, and the result register. Each stage
// holds its contents while the next one is stalled, so back-pressure on the result side
// fills any empty stages before the input side stalls. Configuration registers are meant
// to be written only while no request is in flight; cfg_ready is always high.

module linear_octree_cell_index (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [287:0] s_axis_tdata,   // first_x, first_y, first_z, second_x, second_y,
                                       // second_z, third_x, third_y, third_z (32 bits each)
  input  logic [0:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [23:0]  m_axis_tdata,   // cell_index [15:0], space_level [18:16], zero fill
  output logic [0:0]   m_axis_tuser,   // outside
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CW = loci_pkg::COORD_W;

  // Configuration registers.
  logic signed [CW-1:0] box_min [3];
  logic signed [CW-1:0] box_max [3];
  logic        [31:0]   inv_size;

  // Pipeline occupancy.
  logic v_in, v_a, v_b, v_out;
  logic load_in, load_a, load_b, load_out;

  // Input register.
  logic                 in_op;
  logic signed [CW-1:0] in_c [9];

  // Bounds stage.
  loci_pkg::axis_span_t span [3];
  loci_pkg::axis_span_t a_span [3];
  logic                 a_op;

  // Scaling stage.
  logic [loci_pkg::POS_W-1:0] pos_lo [3];
  logic [loci_pkg::POS_W-1:0] pos_hi [3];
  logic [loci_pkg::POS_W-1:0] b_lo [3];
  logic [loci_pkg::POS_W-1:0] b_hi [3];
  logic                       b_op;
  logic                       b_outside;

  // Result register.
  logic [loci_pkg::INDEX_W-1:0] enc_index;
  logic [loci_pkg::LEVEL_W-1:0] enc_level;
  logic [loci_pkg::INDEX_W-1:0] out_index;
  logic [loci_pkg::LEVEL_W-1:0] out_level;
  logic                         out_outside;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
      inv_size <= loci_pkg::INV_SIZE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        loci_pkg::REG_BOX_MIN_X: box_min[0] <= cfg_data;
        loci_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        loci_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        loci_pkg::REG_BOX_MAX_X: box_max[0] <= cfg_data;
        loci_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        loci_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        loci_pkg::REG_INV_SIZE:  inv_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when its contents move on in the same cycle.
  assign load_out      = !v_out || m_axis_tready;
  assign load_b        = !v_b || load_out;
  assign load_a        = !v_a || load_b;
  assign load_in       = !v_in || load_a;
  assign s_axis_tready = load_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in  <= 1'b0;
      v_a   <= 1'b0;
      v_b   <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (load_in)  v_in  <= s_axis_tvalid;
      if (load_a)   v_a   <= v_in;
      if (load_b)   v_b   <= v_a;
      if (load_out) v_out <= v_b;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_op <= s_axis_tuser[0];
      for (int i = 0; i < 9; i++) begin
        in_c[i] <= s_axis_tdata[CW*i +: CW];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_axis
    loci_bound u_bound (
      .op   (in_op),
      .c0   (in_c[g]),
      .c1   (in_c[g + 3]),
      .c2   (in_c[g + 6]),
      .lo   (box_min[g]),
      .hi   (box_max[g]),
      .span (span[g])
    );

    loci_scale u_scale_lo (
      .off      (a_span[g].off_lo),
      .inv_size (inv_size),
      .grid_pos (pos_lo[g])
    );

    loci_scale u_scale_hi (
      .off      (a_span[g].off_hi),
      .inv_size (inv_size),
      .grid_pos (pos_hi[g])
    );
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_op <= in_op;
      for (int i = 0; i < 3; i++) begin
        a_span[i] <= span[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      b_op      <= a_op;
      b_outside <= (a_op == loci_pkg::OP_POINT) &&
                   (a_span[0].out || a_span[1].out || a_span[2].out);
      for (int i = 0; i < 3; i++) begin
        b_lo[i] <= pos_lo[i];
        b_hi[i] <= pos_hi[i];
      end
    end
  end

  loci_encode u_encode (
    .op          (b_op),
    .outside     (b_outside),
    .lo_x        (b_lo[0]),
    .lo_y        (b_lo[1]),
    .lo_z        (b_lo[2]),
    .hi_x        (b_hi[0]),
    .hi_y        (b_hi[1]),
    .hi_z        (b_hi[2]),
    .cell_index  (enc_index),
    .space_level (enc_level)
  );

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index   <= enc_index;
      out_level   <= enc_level;
      out_outside <= b_outside;
    end
  end

  assign m_axis_tvalid = v_out;
  assign m_axis_tdata  = {5'd0, out_level, out_index};
  assign m_axis_tuser  = out_outside;

endmodule

[hdl/loci_checker.sv]
// Port-level checks on the result stream of the linear octree cell index block.
`timescale 1ns / 1ps

module loci_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A stalled result stays offered unchanged.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed or was dropped");

  // A point outside the cube carries neither index nor level.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[18:0] == 19'd0)
    else $error("outside result carries a nonzero index or level");

  // The level never lies below the deepest level of the tree.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> 32'(m_axis_tdata[18:16]) <= loci_pkg::LEVELS)
    else $error("level beyond tree depth");

  // The fill above the level field is always zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0)
    else $error("nonzero fill bits in result");

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind linear_octree_cell_index loci_checker u_loci_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
